>>> rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing.
`default_nettype none

package spq_pkg;

   // Number of entries, one cell per entry.
   localparam int CAPACITY = 16;
   // Width of the internal entry counter, able to hold CAPACITY itself.
   localparam int CNT_W = $clog2(CAPACITY + 1);
   // Field widths of a beat.
   localparam int VALUE_W = 32;
   localparam int PRIO_W = 16;
   localparam int RSP_CNT_W = 5;

   // Operation codes on req_func.
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   // One stored entry.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic signed [PRIO_W-1:0] priority_val;
   } entry_type;

   // Command broadcast to every cell for one accepted beat.
   typedef struct packed {
      logic push_en;
      logic pop_en;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/spq_cell.sv
// One cell of the queue: holds one entry and moves it to a neighbor on push or pop.
// Depends on spq_pkg for the entry and command types.
`default_nettype none

module spq_cell
   import spq_pkg::*;
(
   input wire logic clock,
   input wire cell_ctrl_type ctrl,
   input wire logic occupied,
   input wire logic prev_lower,
   input wire entry_type prev_entry,
   input wire entry_type next_entry,
   output entry_type entry,
   output logic lower
);

   entry_type entry_ff;
   entry_type entry_in;

   // The new entry goes ahead of this one when this slot is free or holds a
   // strictly lower priority; ties keep arrival order.
   assign lower = !occupied || (entry_ff.priority_val < ctrl.new_entry.priority_val);

   // Next value: on push shift toward the back, on pop shift toward the front.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push_en) begin
         if (lower) begin
            entry_in = prev_lower ? prev_entry : ctrl.new_entry;
         end
      end else if (ctrl.pop_en) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

>>> rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: a row of spq_cell instances plus count logic.
// Depends on spq_pkg and spq_cell.
//
// Channel   Ports                                       Direction  Handshake
// request   start, req_func, req_value, req_priority_req  in       start high, busy low
// response  rsp_valid, rsp_status, rsp_out_value, ...       out      one-cycle strobe
//
// Every accepted beat gives one response beat on the following cycle.
// A new request beat is taken every cycle; each cell compares its own entry
// with the incoming priority and shifts at the next clock edge, so busy stays low.
// Reset clears the entry count and the response strobe; cell contents are
// left as they are and only occupied cells are ever read.
// The receiver cannot stall: each response is shown for exactly one cycle.
`default_nettype none

module sorted_priority_queue
   import spq_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic req_func,
   input wire logic signed [VALUE_W-1:0] req_value,
   input wire logic signed [PRIO_W-1:0] req_priority_req,
   output logic rsp_valid,
   output logic [1:0] rsp_status,
   output logic signed [VALUE_W-1:0] rsp_out_value,
   output logic signed [PRIO_W-1:0] rsp_out_priority,
   output logic [RSP_CNT_W-1:0] rsp_count,
   output logic rsp_is_empty,
   output logic rsp_is_full
);

   logic accept;
   logic is_empty_now;
   logic is_full_now;
   logic push_ok;
   logic pop_ok;
   cell_ctrl_type ctrl;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic rsp_valid_ff;
   status_type rsp_status_ff;
   status_type rsp_status_in;
   entry_type rsp_entry_ff;
   entry_type rsp_entry_in;
   logic [RSP_CNT_W-1:0] rsp_count_ff;
   logic rsp_is_empty_ff;
   logic rsp_is_full_ff;

   entry_type cell_entry [CAPACITY];
   logic cell_lower [CAPACITY];

   // Every cell updates at each clock edge, so a beat can be taken each cycle.
   assign busy = 1'b0;
   assign accept = start && !busy;

   // Decode the operation against the current fill level.
   assign is_empty_now = (count_ff == '0);
   assign is_full_now = (count_ff == CNT_W'(CAPACITY));
   assign push_ok = accept && (req_func == FUNC_PUSH) && !is_full_now;
   assign pop_ok = accept && (req_func == FUNC_POP) && !is_empty_now;

   assign ctrl.push_en = push_ok;
   assign ctrl.pop_en = pop_ok;
   assign ctrl.new_entry.value = req_value;
   assign ctrl.new_entry.priority_val = req_priority_req;

   // Row of cells, front of the queue at index zero.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic occ;
      logic lower_from_prev;
      entry_type from_prev;
      entry_type from_next;

      assign occ = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_front
         assign lower_from_prev = 1'b0;
         assign from_prev = ctrl.new_entry;
      end else begin : g_inner
         assign lower_from_prev = cell_lower[i-1];
         assign from_prev = cell_entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_back
         assign from_next = cell_entry[i];
      end else begin : g_body
         assign from_next = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock(clock),
         .ctrl(ctrl),
         .occupied(occ),
         .prev_lower(lower_from_prev),
         .prev_entry(from_prev),
         .next_entry(from_next),
         .entry(cell_entry[i]),
         .lower(cell_lower[i])
      );
   end

   // Count and response contents for the accepted beat.
   always_comb begin
      count_in = count_ff;
      rsp_status_in = STATUS_OK;
      rsp_entry_in = '0;
      if (push_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok) begin
         count_in = count_ff - CNT_W'(1);
         rsp_entry_in = cell_entry[0];
      end else if (accept && (req_func == FUNC_POP)) begin
         rsp_status_in = STATUS_EMPTY;
      end else if (accept) begin
         rsp_status_in = STATUS_FULL;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_entry_ff <= rsp_entry_in;
         rsp_count_ff <= RSP_CNT_W'(count_in);
         rsp_is_empty_ff <= (count_in == '0);
         rsp_is_full_ff <= (count_in == CNT_W'(CAPACITY));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_out_value = rsp_entry_ff.value;
   assign rsp_out_priority = rsp_entry_ff.priority_val;
   assign rsp_count = rsp_count_ff;
   assign rsp_is_empty = rsp_is_empty_ff;
   assign rsp_is_full = rsp_is_full_ff;

   // The fill level never passes the number of cells.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // A refused beat leaves the fill level alone.
   a_refused_keeps_count : assert property (@(posedge clock) disable iff (reset)
      accept && !push_ok && !pop_ok |=> $stable(count_ff))
      else $error("refused beat changed the count");

   // A pop on an empty queue reports the empty status on the next beat.
   a_empty_pop_status : assert property (@(posedge clock) disable iff (reset)
      accept && (req_func == FUNC_POP) && is_empty_now
      |=> rsp_valid && (rsp_status == STATUS_EMPTY))
      else $error("empty pop not reported");

   // With two or more entries, the front never has lower priority than its neighbor.
   a_front_order : assert property (@(posedge clock) disable iff (reset)
      (count_ff > CNT_W'(1)) |-> cell_entry[0].priority_val >= cell_entry[1].priority_val)
      else $error("queue order broken at the front");

endmodule

`default_nettype wire

>>> tb/sorted_priority_queue_tb.sv
// Self-checking testbench for sorted_priority_queue: a directed table, then random
// push/pop traffic with sender gaps, checked against a behavioral model or typed-in rows.
// Depends on spq_pkg and the sorted_priority_queue RTL.

module sorted_priority_queue_tb;
   import spq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD_NS = 2;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_PER_PHASE = 342;
   localparam int CYCLE_LIMIT = 200_000;
   localparam int DRAIN_CYCLES = 8;

   // One request beat.
   typedef struct packed {
      logic func;
      logic signed [VALUE_W-1:0] value;
      logic signed [PRIO_W-1:0] prio;
   } op_beat_t;

   // One response beat.
   typedef struct packed {
      status_type status;
      logic signed [VALUE_W-1:0] out_value;
      logic signed [PRIO_W-1:0] out_priority;
      logic [RSP_CNT_W-1:0] count;
      logic is_empty;
      logic is_full;
   } queue_result_t;

   // Directed row; when typed is set the response fields are written out by hand.
   typedef struct packed {
      logic func;
      logic signed [VALUE_W-1:0] value;
      logic signed [PRIO_W-1:0] prio;
      logic typed;
      status_type status;
      logic signed [VALUE_W-1:0] out_value;
      logic signed [PRIO_W-1:0] out_priority;
      logic [RSP_CNT_W-1:0] count;
   } directed_row_t;

   localparam int DIRECTED_COUNT = 25;
   localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // Pop on an empty queue, then pushes at both priority extremes.
      '{FUNC_POP,  32'sh0000_0000, 16'sh0000, 1'b1, STATUS_EMPTY, 32'sh0, 16'sh0, 5'd0},
      '{FUNC_PUSH, 32'sh7FFF_FFFF, 16'sh7FFF, 1'b1, STATUS_OK, 32'sh0, 16'sh0, 5'd1},
      '{FUNC_PUSH, 32'sh8000_0000, 16'sh8000, 1'b1, STATUS_OK, 32'sh0, 16'sh0, 5'd2},
      // Two entries of equal priority must leave in arrival order.
      '{FUNC_PUSH, 32'sh0000_00AA, 16'sh0000, 1'b1, STATUS_OK, 32'sh0, 16'sh0, 5'd3},
      '{FUNC_PUSH, 32'sh0000_0055, 16'sh0000, 1'b1, STATUS_OK, 32'sh0, 16'sh0, 5'd4},
      '{FUNC_POP,  32'sh1234_5678, 16'sh1234, 1'b1, STATUS_OK, 32'sh7FFF_FFFF, 16'sh7FFF, 5'd3},
      '{FUNC_POP,  32'sh0000_0000, 16'sh0000, 1'b1, STATUS_OK, 32'sh0000_00AA, 16'sh0000, 5'd2},
      // Fill to capacity, inserting at the front, the back and in between.
      '{FUNC_PUSH, 32'shFFFF_FFFF, 16'shFFFF, 1'b0, STATUS_OK, 32'sh0, 16'sh0, 5'd0},
      '{FUNC_PUSH, 32'sh0000_0001, 16'sh7FFF, 1'b0, STATUS_OK, 32'sh0, 16'sh0, 5'd0},
      '{FUNC_PUSH, 32'sh0000_0002, 16'sh8000, 1'b0, STATUS_OK, 32'sh0, 16'sh0, 5'd0},
      '{FUNC_PUSH, 32'sh0000_0003, 16'sh0000, 1'b0, STATUS_OK, 32'sh0, 16'sh0, 5'd0},
      '{FUNC_PUSH, 32'sh0000_0004, 16'sh0001, 1'b0, STATUS_OK, 32'sh0, 16'sh0, 5'd0},
      '{FUNC_PUSH, 32'sh5555_5555, 16'shFFFF, 1'b0, STATUS_OK, 32'sh0, 16'sh0, 5'd0},
      '{FUNC_PUSH, 32'shAAAA_AAAA, 16'sh0064, 1'b0, STATUS_OK, 32'sh0, 16'sh0, 5'd0},
      '{FUNC_PUSH, 32'sh0F0F_0F0F, 16'shFF9C, 1'b0, STATUS_OK, 32'sh0, 16'sh0, 5'd0},
      '{FUNC_PUSH, 32'shF0F0_F0F0, 16'sh7FFE, 1'b0, STATUS_OK, 32'sh0, 16'sh0, 5'd0},
      '{FUNC_PUSH, 32'sh00FF_00FF, 16'sh8001, 1'b0, STATUS_OK, 32'sh0, 16'sh0, 5'd0},
      '{FUNC_PUSH, 32'shFF00_FF00, 16'sh0000, 1'b0, STATUS_OK, 32'sh0, 16'sh0, 5'd0},
      '{FUNC_PUSH, 32'sh3333_3333, 16'sh7FFF, 1'b0, STATUS_OK, 32'sh0, 16'sh0, 5'd0},
      '{FUNC_PUSH, 32'shCCCC_CCCC, 16'sh0002, 1'b0, STATUS_OK, 32'sh0, 16'sh0, 5'd0},
      '{FUNC_PUSH, 32'sh6666_6666, 16'shFFFE, 1'b0, STATUS_OK, 32'sh0, 16'sh0, 5'd0},
      // Push on a full queue is refused and leaves the contents alone.
      '{FUNC_PUSH, 32'sh7777_7777, 16'sh7FFF, 1'b1, STATUS_FULL, 32'sh0, 16'sh0, 5'd16},
      '{FUNC_POP,  32'shFFFF_FFFF, 16'shFFFF, 1'b0, STATUS_OK, 32'sh0, 16'sh0, 5'd0},
      '{FUNC_PUSH, 32'sh9999_9999, 16'sh8000, 1'b0, STATUS_OK, 32'sh0, 16'sh0, 5'd0},
      '{FUNC_POP,  32'sh0000_0000, 16'sh0000, 1'b0, STATUS_OK, 32'sh0, 16'sh0, 5'd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_func = FUNC_PUSH;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic signed [PRIO_W-1:0] req_priority_req = '0;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic signed [VALUE_W-1:0] rsp_out_value;
   logic signed [PRIO_W-1:0] rsp_out_priority;
   logic [RSP_CNT_W-1:0] rsp_count;
   logic rsp_is_empty;
   logic rsp_is_full;

   // Behavioral copy of the queue contents, kept in service order.
   logic signed [VALUE_W-1:0] held_value [CAPACITY];
   logic signed [PRIO_W-1:0] held_prio [CAPACITY];
   int held_count = 0;

   queue_result_t awaited_results [$];
   int sender_idle_pct = 0;
   int cycle_count = 0;
   int mismatches = 0;
   int pushes_done = 0;
   int pops_done = 0;
   int full_rejects = 0;
   int empty_rejects = 0;
   int peak_fill = 0;

   sorted_priority_queue DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_value(req_value),
      .req_priority_req(req_priority_req),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_out_value(rsp_out_value),
      .rsp_out_priority(rsp_out_priority),
      .rsp_count(rsp_count),
      .rsp_is_empty(rsp_is_empty),
      .rsp_is_full(rsp_is_full)
   );

   // Free-running clock, 4 ns period.
   always #HALF_PERIOD_NS clock = ~clock;

   // Watchdog: a hung handshake ends the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Applies one operation to the queue copy and returns the response it should give.
   function automatic queue_result_t apply_queue_op(input op_beat_t b);
      queue_result_t r;
      int slot;
      int i;
      r = '0;
      r.status = STATUS_OK;
      if (b.func == FUNC_POP) begin
         if (held_count == 0) begin
            r.status = STATUS_EMPTY;
            empty_rejects++;
         end else begin
            r.out_value = held_value[0];
            r.out_priority = held_prio[0];
            for (i = 1; i < held_count; i++) begin
               held_value[i-1] = held_value[i];
               held_prio[i-1] = held_prio[i];
            end
            held_count--;
            pops_done++;
         end
      end else if (held_count >= CAPACITY) begin
         r.status = STATUS_FULL;
         full_rejects++;
      end else begin
         // New entry goes just ahead of the first one with strictly lower priority.
         slot = held_count;
         for (i = held_count - 1; i >= 0; i--) begin
            if (held_prio[i] < b.prio) slot = i;
         end
         for (i = held_count; i > slot; i--) begin
            held_value[i] = held_value[i-1];
            held_prio[i] = held_prio[i-1];
         end
         held_value[slot] = b.value;
         held_prio[slot] = b.prio;
         held_count++;
         pushes_done++;
      end
      if (held_count > peak_fill) peak_fill = held_count;
      r.count = RSP_CNT_W'(held_count);
      r.is_empty = (held_count == 0);
      r.is_full = (held_count == CAPACITY);
      return r;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatches++;
      end
   endfunction

   // Response checker: every strobed beat is matched against the oldest expectation.
   always @(posedge clock) begin
      queue_result_t want;
      if (!reset && rsp_valid) begin
         if (awaited_results.size() == 0) begin
            $error("response beat with no request outstanding");
            mismatches++;
         end else begin
            want = awaited_results.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("out_value", want.out_value, rsp_out_value);
            check_field("out_priority", 32'(want.out_priority), 32'(rsp_out_priority));
            check_field("count", 32'(want.count), 32'(rsp_count));
            check_field("is_empty", 32'(want.is_empty), 32'(rsp_is_empty));
            check_field("is_full", 32'(want.is_full), 32'(rsp_is_full));
         end
      end
   end

   // Drives one request beat, with random gaps ahead of it, and records its expectation.
   task automatic send_beat(input op_beat_t b, input logic use_typed,
                            input queue_result_t typed_res);
      queue_result_t predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_func <= b.func;
      req_value <= b.value;
      req_priority_req <= b.prio;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = apply_queue_op(b);
      awaited_results.push_back(use_typed ? typed_res : predicted);
   endtask

   // Holds the request side quiet until every outstanding response has been checked.
   task automatic await_drain();
      start <= 1'b0;
      while (awaited_results.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Random beat; the push share steers the fill level between empty and full.
   function automatic op_beat_t random_beat(input int push_pct);
      op_beat_t b;
      b.func = ($urandom_range(99) < push_pct) ? FUNC_PUSH : FUNC_POP;
      b.value = $urandom;
      case ($urandom_range(3))
         0, 1: begin
            // Narrow band so that ties are common.
            b.prio = PRIO_W'($urandom_range(6) - 3);
         end
         2: begin
            b.prio = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         end
         default: begin
            b.prio = PRIO_W'($urandom);
         end
      endcase
      return b;
   endfunction

   initial begin : stimulus
      directed_row_t row;
      op_beat_t b;
      queue_result_t typed_res;
      int phase;
      int n;
      int burst_left;
      int push_pct;

      burst_left = 0;
      push_pct = 50;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      sender_idle_pct = 13;
      for (n = 0; n < DIRECTED_COUNT; n++) begin
         row = DIRECTED_ROWS[n];
         b.func = row.func;
         b.value = row.value;
         b.prio = row.prio;
         typed_res.status = row.status;
         typed_res.out_value = row.out_value;
         typed_res.out_priority = row.out_priority;
         typed_res.count = row.count;
         typed_res.is_empty = (row.count == 0);
         typed_res.is_full = (row.count == CAPACITY);
         send_beat(b, row.typed, typed_res);
      end
      await_drain();

      // Random traffic in bursts of push-heavy, balanced and pop-heavy mixes.
      for (phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 63 : 0;
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(60, 10);
               case ($urandom_range(2))
                  0: push_pct = 85;
                  1: push_pct = 50;
                  default: push_pct = 15;
               endcase
            end
            burst_left--;
            send_beat(random_beat(push_pct), 1'b0, '0);
            if ($urandom_range(99) == 0) await_drain();
         end
         await_drain();
      end

      // Let any stray response beat show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d pushes and %0d pops, with %0d pushes refused on full",
               pushes_done, pops_done, full_rejects);
      $display("and %0d pops on empty; peak fill was %0d of %0d entries.",
               empty_rejects, peak_fill, CAPACITY);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
